@@ sv/joint_sigmoid_friction_macros.svh @@
// Assertion macros used by the sigmoid joint friction RTL (joint_sigmoid_friction).
// Expects clk and rst in the scope of the module that uses them.
`ifndef JOINT_SIGMOID_FRICTION_MACROS_SVH
`define JOINT_SIGMOID_FRICTION_MACROS_SVH

// Same-cycle implication on the rising edge of clk, off while rst is high.
`define JSF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on the rising edge of clk, off while rst is high.
`define JSF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/jsf_pkg.sv @@
// Shared widths, fixed-point constants and per-joint coefficient tables.
// No dependencies; used by jsf_sigmoid and joint_sigmoid_friction.
`timescale 1ns / 1ps
`default_nettype none

package jsf_pkg;

  localparam int JOINTS_DEF   = 7;
  localparam int JOINT_W      = 3;
  localparam int VEL_W        = 16;
  localparam int TRQ_W        = 16;
  localparam int AMP_W        = 17;
  localparam int SLOPE_W      = 21;
  localparam int OFS_W        = 17;
  localparam int W_W          = 25;
  localparam int SERIES_TERMS = 9;
  localparam int DIV_STEPS    = 31;
  // magnitude, product, round, product, round, z, series, final sum,
  // shift/denominator, quotient bits, sign fold
  localparam int SIG_LAT      = 6 + 2 * (SERIES_TERMS - 1) + 2 + DIV_STEPS + 1;

  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;

  typedef logic [30:0]                prob_t;
  typedef logic [JOINT_W-1:0]         joint_t;
  typedef logic [AMP_W-1:0]           amp_t;
  typedef logic [SLOPE_W-1:0]         slope_t;
  typedef logic signed [OFS_W-1:0]    ofs_t;
  typedef logic signed [W_W-1:0]      wv_t;
  typedef logic signed [TRQ_W-1:0]    trq_t;

  // Amplitude, unsigned Q.16
  function automatic amp_t amp_lut(input joint_t j);
    amp_t a;
    unique case (j)
      3'd0:    a = 17'd35792;
      3'd1:    a = 17'd57163;
      3'd2:    a = 17'd41988;
      3'd3:    a = 17'd83847;
      3'd4:    a = 17'd54987;
      3'd5:    a = 17'd19858;
      3'd6:    a = 17'd37021;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Slope, unsigned Q.16
  function automatic slope_t slope_lut(input joint_t j);
    slope_t k;
    unique case (j)
      3'd0:    k = 21'd335420;
      3'd1:    k = 21'd594130;
      3'd2:    k = 21'd664273;
      3'd3:    k = 21'd366366;
      3'd4:    k = 21'd547022;
      3'd5:    k = 21'd1122828;
      3'd6:    k = 21'd677380;
      default: k = '0;
    endcase
    return k;
  endfunction

  // Offset, signed Q.20
  function automatic ofs_t offset_lut(input joint_t j);
    ofs_t c;
    unique case (j)
      3'd0:    c = 17'sd41453;
      3'd1:    c = 17'sd27139;
      3'd2:    c = -17'sd48308;
      3'd3:    c = 17'sd37952;
      3'd4:    c = 17'sd27500;
      3'd5:    c = -17'sd22069;
      3'd6:    c = 17'sd3725;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Reciprocal multiplier m = ceil(2^s / d); exact floor(p / d) for p < 2^30
  function automatic logic [30:0] recip_mult(input int d);
    logic [30:0] m;
    unique case (d)
      3:       m = 31'd1431655766;
      5:       m = 31'd1717986919;
      6:       m = 31'd1431655766;
      7:       m = 31'd1227133514;
      9:       m = 31'd1908874354;
      default: m = 31'h4000_0000;
    endcase
    return m;
  endfunction

  function automatic int recip_shift(input int d);
    int s;
    unique case (d)
      2:       s = 31;
      3:       s = 32;
      4:       s = 32;
      5:       s = 33;
      6:       s = 33;
      7:       s = 33;
      8:       s = 33;
      9:       s = 34;
      default: s = 30;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ sv/jsf_sigmoid.sv @@
// Pipelined logistic sigmoid S(K*w) in Q.30: exp by a Taylor series, 1/(1+e) by
// a one-bit-per-stage restoring divider. Depends on jsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsf_sigmoid (
  input  logic           clk,
  input  logic           en,
  input  jsf_pkg::wv_t   w,
  input  jsf_pkg::slope_t k,
  output jsf_pkg::prob_t s
);
  import jsf_pkg::*;

  logic [W_W-1:0] w_abs;
  logic           neg1, neg2, neg3, neg4, neg5;
  logic [23:0]    wm1;
  slope_t         k1;
  logic [44:0]    tp2;
  logic [44:0]    tsum;
  logic [23:0]    t3;
  logic [54:0]    yp4;
  logic [54:0]    ysum;
  logic [8:0]     n5;
  logic [15:0]    f5;
  logic [45:0]    zp;

  // series state after each divide stage; index 1 holds the first term
  logic [29:0] dt_term [1:SERIES_TERMS];
  logic [30:0] dt_acc  [1:SERIES_TERMS];
  logic [29:0] dt_z    [1:SERIES_TERMS];
  logic [8:0]  dt_n    [1:SERIES_TERMS];
  logic        dt_neg  [1:SERIES_TERMS];

  logic [29:0] mp_pm  [2:SERIES_TERMS];
  logic [30:0] mp_acc [2:SERIES_TERMS];
  logic [29:0] mp_z   [2:SERIES_TERMS];
  logic [8:0]  mp_n   [2:SERIES_TERMS];
  logic        mp_neg [2:SERIES_TERMS];

  logic [30:0] af_acc;
  logic [8:0]  af_n;
  logic        af_neg;
  logic [30:0] e_val;

  logic [30:0] dv_r   [0:DIV_STEPS];
  logic [30:0] dv_q   [0:DIV_STEPS];
  logic [31:0] dv_den [0:DIV_STEPS];
  logic        dv_neg [0:DIV_STEPS];

  assign w_abs = w[W_W-1] ? W_W'(-w) : W_W'(w);
  assign tsum  = tp2 + 45'd524288;
  assign ysum  = yp4 + 55'd536870912;
  assign zp    = f5 * LN2_Q30;

  // magnitude, slope product, rounding, log2(e) product, split into n and f, then z = f*ln2
  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= w[W_W-1];
      wm1  <= w_abs[23:0];
      k1   <= k;
      neg2 <= neg1;
      tp2  <= k1 * wm1;
      neg3 <= neg2;
      t3   <= tsum[43:20];
      neg4 <= neg3;
      yp4  <= t3 * LOG2E_Q30;
      neg5 <= neg4;
      n5   <= ysum[54:46];
      f5   <= ysum[45:30];
      dt_term[1] <= zp[45:16];
      dt_acc[1]  <= ONE_Q30;
      dt_z[1]    <= zp[45:16];
      dt_n[1]    <= n5;
      dt_neg[1]  <= neg5;
    end
  end

  // one multiply stage and one reciprocal divide stage per series term
  for (genvar t = 2; t <= SERIES_TERMS; t++) begin : g_term
    localparam logic [30:0] RM  = recip_mult(t);
    localparam int          RS  = recip_shift(t);
    localparam bit          SUB = ((t % 2) == 0);

    logic [59:0] mprod;
    logic [60:0] dprod;
    logic [60:0] dsh;
    logic [30:0] acc_next;

    assign mprod = dt_term[t-1] * dt_z[t-1];
    assign dprod = mp_pm[t] * RM;
    assign dsh   = dprod >> RS;

    always_comb begin
      if (SUB) begin
        acc_next = dt_acc[t-1] - {1'b0, dt_term[t-1]};
      end else begin
        acc_next = dt_acc[t-1] + {1'b0, dt_term[t-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mp_pm[t]   <= mprod[59:30];
        mp_acc[t]  <= acc_next;
        mp_z[t]    <= dt_z[t-1];
        mp_n[t]    <= dt_n[t-1];
        mp_neg[t]  <= dt_neg[t-1];
        dt_term[t] <= dsh[29:0];
        dt_acc[t]  <= mp_acc[t];
        dt_z[t]    <= mp_z[t];
        dt_n[t]    <= mp_n[t];
        dt_neg[t]  <= mp_neg[t];
      end
    end
  end

  // past 30 the shift clears the value anyway
  assign e_val = (af_n > 9'd30) ? '0 : (af_acc >> af_n[4:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      af_acc    <= dt_acc[SERIES_TERMS] - {1'b0, dt_term[SERIES_TERMS]};
      af_n      <= dt_n[SERIES_TERMS];
      af_neg    <= dt_neg[SERIES_TERMS];
      // numerator is 2^60 + den/2: the top part is always 2^29
      dv_r[0]   <= 31'h2000_0000;
      dv_q[0]   <= '0;
      dv_den[0] <= {1'b0, ONE_Q30} + {1'b0, e_val};
      dv_neg[0] <= af_neg;
    end
  end

  // restoring division, one quotient bit per stage, numerator low bits = den >> 1
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [31:0] rs;
    logic [31:0] diff;
    logic        ge;

    assign rs   = {dv_r[i], dv_den[i][DIV_STEPS-i]};
    assign ge   = (rs >= dv_den[i]);
    assign diff = rs - dv_den[i];

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[i+1]   <= ge ? diff[30:0] : rs[30:0];
        dv_q[i+1]   <= {dv_q[i][29:0], ge};
        dv_den[i+1] <= dv_den[i];
        dv_neg[i+1] <= dv_neg[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s <= dv_neg[DIV_STEPS] ? (ONE_Q30 - dv_q[DIV_STEPS]) : dv_q[DIV_STEPS];
    end
  end

endmodule

`default_nettype wire

@@ sv/joint_sigmoid_friction.sv @@
// Sigmoid joint friction: torque = A * (S(K*(v+C)) - S(K*C)), Q3.12 in, Q1.14 out.
// Depends on jsf_pkg, jsf_sigmoid and joint_sigmoid_friction_macros.svh.
//
//   Channel | Role   | Handshake                   | Payload
//   sample  | input  | sample_valid / sample_stall | joint[2:0], velocity[15:0]
//   torque  | output | torque_valid / torque_stall | joint_out[2:0], friction_torque[15:0]
//
// Throughput is one request per clock while sample_stall is low. On its way to
// the output register a request passes the 56 stages of jsf_sigmoid (9-term
// series, then a 31-stage quotient pipeline). Reset (rst, synchronous) clears the
// valid bits only. A stalled result waits in the output register while the
// pipeline keeps flowing; a second finished request parks in a skid register, and
// only then does sample_stall rise and the whole pipeline hold.
`timescale 1ns / 1ps
`default_nettype none
`include "joint_sigmoid_friction_macros.svh"

module joint_sigmoid_friction #(
  parameter int JOINTS = jsf_pkg::JOINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  jsf_pkg::joint_t       joint,
  input  logic signed [jsf_pkg::VEL_W-1:0] velocity,
  output logic                  torque_valid,
  input  logic                  torque_stall,
  output jsf_pkg::joint_t       joint_out,
  output jsf_pkg::trq_t         friction_torque
);
  import jsf_pkg::*;

  logic        en;

  // input register
  logic        v0;
  joint_t      j0;
  logic signed [VEL_W-1:0] vel0;

  // table lookup and sigmoid arguments
  logic        in_rng;
  ofs_t        ofs0;
  logic signed [23:0] vel_sh;
  logic        v1;
  joint_t      j1;
  amp_t        amp1;
  slope_t      k1;
  wv_t         w_main1;
  wv_t         w_bias1;

  // sideband that rides along the sigmoid stages
  logic [SIG_LAT-1:0] vld_line;
  joint_t      jnt_line [SIG_LAT];
  amp_t        amp_line [SIG_LAT];
  prob_t       s_main;
  prob_t       s_bias;

  // difference and amplitude product
  logic [31:0] d_diff;
  logic [31:0] d_abs;
  logic        v2;
  joint_t      j2;
  amp_t        amp2;
  logic        dneg2;
  logic [30:0] dm2;
  logic        v3;
  joint_t      j3;
  logic        dneg3;
  logic [47:0] prod3;

  // rounding, saturation, output side
  logic [47:0] rsum;
  logic [15:0] mag;
  trq_t        fin_torque;
  logic        arrival;
  logic        skid_valid;
  joint_t      skid_joint;
  trq_t        skid_torque;

  // the pipeline advances as one; only a full skid register holds it
  assign en           = !skid_valid;
  assign sample_stall = skid_valid;

  assign in_rng = ({1'b0, j0} < 4'(JOINTS));
  assign ofs0   = offset_lut(j0);
  assign vel_sh = {vel0, 8'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      vld_line <= '0;
      v2       <= 1'b0;
      v3       <= 1'b0;
    end else if (en) begin
      v0       <= sample_valid;
      v1       <= v0;
      vld_line <= {vld_line[SIG_LAT-2:0], v1};
      v2       <= vld_line[SIG_LAT-1];
      v3       <= v2;
    end
  end

  // capture the request, look up coefficients, widen velocity to Q.20 and add C
  always_ff @(posedge clk) begin
    if (en) begin
      j0      <= joint;
      vel0    <= velocity;
      j1      <= j0;
      amp1    <= in_rng ? amp_lut(j0) : '0;
      k1      <= slope_lut(j0);
      w_main1 <= {vel_sh[23], vel_sh} + {{(W_W-OFS_W){ofs0[OFS_W-1]}}, ofs0};
      w_bias1 <= {{(W_W-OFS_W){ofs0[OFS_W-1]}}, ofs0};
    end
  end

  // velocity term and the per-joint bias term run in two matched lanes
  jsf_sigmoid u_sig_main (
    .clk (clk),
    .en  (en),
    .w   (w_main1),
    .k   (k1),
    .s   (s_main)
  );

  jsf_sigmoid u_sig_bias (
    .clk (clk),
    .en  (en),
    .w   (w_bias1),
    .k   (k1),
    .s   (s_bias)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      jnt_line[0] <= j1;
      amp_line[0] <= amp1;
      for (int i = 1; i < SIG_LAT; i++) begin
        jnt_line[i] <= jnt_line[i-1];
        amp_line[i] <= amp_line[i-1];
      end
    end
  end

  // difference in Q.30 as sign and magnitude
  assign d_diff = {1'b0, s_main} - {1'b0, s_bias};
  assign d_abs  = d_diff[31] ? (~d_diff + 32'd1) : d_diff;

  always_ff @(posedge clk) begin
    if (en) begin
      j2    <= jnt_line[SIG_LAT-1];
      amp2  <= amp_line[SIG_LAT-1];
      dneg2 <= d_diff[31];
      dm2   <= d_abs[30:0];
      j3    <= j2;
      dneg3 <= dneg2;
      prod3 <= amp2 * dm2;
    end
  end

  // Q.46 to Q.14: round the magnitude half up, then clamp to 16 bits
  assign rsum = prod3 + 48'h0000_8000_0000;
  assign mag  = rsum[47:32];

  always_comb begin
    if (dneg3) begin
      fin_torque = (mag > 16'd32768) ? 16'sh8000 : trq_t'(~mag + 16'd1);
    end else begin
      fin_torque = (mag > 16'd32767) ? 16'sh7fff : trq_t'(mag);
    end
  end

  assign arrival = en && v3;

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      torque_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (!torque_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (arrival) begin
      if (torque_valid && torque_stall) begin
        skid_valid <= 1'b1;
      end else begin
        torque_valid <= 1'b1;
      end
    end else if (!torque_stall) begin
      torque_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!torque_stall) begin
        joint_out       <= skid_joint;
        friction_torque <= skid_torque;
      end
    end else if (arrival) begin
      if (torque_valid && torque_stall) begin
        skid_joint  <= j3;
        skid_torque <= fin_torque;
      end else begin
        joint_out       <= j3;
        friction_torque <= fin_torque;
      end
    end
  end

  `JSF_ASSERT_IMP(a_skid_behind_out, skid_valid, torque_valid, "skid full while output register empty")
  `JSF_ASSERT_NXT(a_skid_catches, (!skid_valid && v3 && torque_valid && torque_stall), skid_valid, "finished request dropped under stall")
  `JSF_ASSERT_NXT(a_skid_drains, (skid_valid && !torque_stall), (torque_valid && !skid_valid), "skid request not moved to output")
  `JSF_ASSERT_IMP(a_unknown_joint_zero, (torque_valid && ({1'b0, joint_out} >= 4'(JOINTS))), (friction_torque == '0), "nonzero torque for joint outside table")

endmodule

`default_nettype wire
